@@ sv/pstc_pkg.sv @@
`timescale 1ns / 1ps
package pstc_pkg;

  // Field and datapath widths
  localparam int RangeW  = 16;
  localparam int AngleW  = 32;
  localparam int OutW    = 17;
  localparam int GainW   = 31;
  localparam int ProdW   = RangeW + GainW;
  localparam int XyW     = 35;
  localparam int ZW      = 33;
  localparam int CntW    = 5;
  localparam int CfgIdxW = 2;

  // Micro-rotation count (8..32)
  localparam int CordicStages = 16;

  // CORDIC gain limit in Q31
  localparam logic [GainW-1:0] GainQ31 = 31'd1304065748;
  localparam logic [OutW-1:0]  OutMax  = 17'd65535;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegStartAngle = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAngleStep  = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROT,
    ST_FIN
  } pstc_state_t;

  // atan(2^-i) in binary-angle units
  function automatic logic [AngleW-1:0] atan_lut(input logic [CntW-1:0] idx);
    logic [AngleW-1:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ sv/polar_scan_to_cartesian_core.sv @@
`timescale 1ns / 1ps
// Channel | Dir | tdata (low bit up)              | tuser (low bit up)
// in_     | in  | range_mm[15:0]                   | range_finite, scan_start
// out_    | out | x_mm[16:0], y_mm[33:17], 6 zero  | -
// cfg_    | in  | start_angle / angle_step by cfg_addr
//
// A finite sample is taken in idle, then goes through the bit-serial gain
// prescale (one range bit per cycle), the micro-rotations on the shared
// unit and rounding. A non-finite sample is taken in idle and gives no result.
// Reset (sync, rst_n low) clears the angle, config registers and handshake state.
// A stalled result sits in the output register; the next sample is taken
// meanwhile and waits in rounding until the register frees.
module polar_scan_to_cartesian_core
  import pstc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // range_mm
  input  logic [1:0]           in_tuser,   // range_finite, scan_start
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // x_mm, y_mm, zero pad
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_addr,
  input  logic [AngleW-1:0]    cfg_wdata
);

  localparam logic [CntW-1:0] MulLast = CntW'(RangeW - 1);
  localparam logic [CntW-1:0] RotLast = CntW'(CordicStages - 1);

  pstc_state_t state_r, state_nxt;
  logic [AngleW-1:0] start_angle_r, angle_step_r, cur_angle_r, cur_angle_nxt;
  logic [RangeW-1:0] rng_r, rng_nxt;
  logic [ProdW-1:0]  acc_r, acc_nxt;
  logic signed [XyW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic              ov_r, ov_nxt;
  logic [OutW-1:0]   ox_r, ox_nxt, oy_r, oy_nxt;

  logic              in_xfer, out_xfer;
  logic [AngleW-1:0] ang, ang_f;
  logic              fold;
  logic signed [XyW-1:0] xs, ys;
  logic signed [ZW-1:0]  atn;

  // Round by 2^16, negate on fold, clamp to +/-65535
  function automatic logic [OutW-1:0] finish(input logic signed [XyW-1:0] v,
                                             input logic neg);
    logic signed [XyW:0] t;
    logic signed [XyW:0] lim;
    t = (XyW+1)'(signed'(v) + (XyW+1)'(32768)) >>> 16;
    if (neg) t = -t;
    lim = (XyW+1)'(OutMax);
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t[OutW-1:0];
  endfunction

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = ov_r && out_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, oy_r, ox_r};

  // Sample angle and half-turn fold
  assign ang   = in_tuser[1] ? start_angle_r : cur_angle_r;
  assign fold  = ang[31] ^ ang[30];
  assign ang_f = fold ? (ang ^ 32'h80000000) : ang;

  assign xs  = x_r >>> cnt_r;
  assign ys  = y_r >>> cnt_r;
  assign atn = ZW'(atan_lut(cnt_r));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == RegStartAngle) start_angle_r <= cfg_wdata;
      if (cfg_addr == RegAngleStep)  angle_step_r  <= cfg_wdata;
    end
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_angle_r <= '0;
      ov_r        <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_angle_r <= cur_angle_nxt;
      ov_r        <= ov_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rng_r <= rng_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
    ox_r  <= ox_nxt;
    oy_r  <= oy_nxt;
  end

  // Next state, serial multiply and micro-rotation
  always_comb begin
    state_nxt     = state_r;
    cur_angle_nxt = cur_angle_r;
    rng_nxt       = rng_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    ov_nxt        = ov_r && !out_xfer;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cur_angle_nxt = ang + angle_step_r;
          rng_nxt       = in_tdata;
          neg_nxt       = fold;
          z_nxt         = ZW'(signed'(ang_f));
          acc_nxt       = '0;
          cnt_nxt       = '0;
          if (in_tuser[0]) state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_nxt = (acc_r << 1) + (rng_r[RangeW-1] ? ProdW'(GainQ31) : '0);
        rng_nxt = rng_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MulLast) begin
          x_nxt     = XyW'((acc_nxt + ProdW'(16384)) >> 15);
          y_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        if (!z_r[ZW-1]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - atn;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + atn;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RotLast) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!ov_r || out_xfer) begin
          ox_nxt    = finish(x_r, neg_r);
          oy_nxt    = finish(y_r, neg_r);
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Checks
  a_rot_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROT |-> cnt_r <= RotLast)
    else $error("rotation count past last stage");
  a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> cnt_r <= MulLast)
    else $error("multiply count past last bit");
  a_finite_go: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser[0] |=> state_r == ST_MUL)
    else $error("finite sample did not start prescale");
  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_tuser[0] |=> state_r == ST_IDLE && $stable(ox_r))
    else $error("non-finite sample disturbed result");
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && (!ov_r || out_tready) |=> ov_r)
    else $error("result not loaded");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import pstc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // range_mm
  logic [1:0]  in_tuser = '0;   // range_finite, scan_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // x_mm, y_mm, zero pad
  logic        cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_addr = '0;
  logic [AngleW-1:0]  cfg_wdata = '0;

  int unsigned n_fail = 0;
  int unsigned n_points = 0;
  int unsigned n_samples = 0;
  bit          quiet = 1'b0;   // no idling stretch

  always #2 clk = ~clk;

  polar_scan_to_cartesian_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
  } point_t;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    n_fail++;
  endtask

  // Predicts the point for each finite sample and holds points still due
  class point_scoreboard;
    logic [31:0] start_ang, step_ang, cur_ang;
    point_t      due_q[$];

    function new();
      start_ang = '0; step_ang = '0; cur_ang = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] v);
      if (idx == RegStartAngle) start_ang = v;
      else if (idx == RegAngleStep) step_ang = v;
    endfunction

    static function longint shr(longint v, int s);
      return v >>> s;
    endfunction

    static function logic signed [16:0] round_out(longint v, bit neg);
      longint r;
      r = (v + 32768) >>> 16;
      if (neg) r = -r;
      if (r > 65535) r = 65535;
      if (r < -65535) r = -65535;
      return r[16:0];
    endfunction

    // Angle bookkeeping, then CORDIC rotation for finite samples
    function void note_sample(logic [15:0] r, bit fin, bit st);
      logic [31:0] a;
      bit          neg;
      longint      x, y, z, xn, k;
      point_t      p;
      a = st ? start_ang : cur_ang;
      cur_ang = a + step_ang;
      if (!fin) return;
      neg = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
      if (neg) a = a ^ 32'h8000_0000;
      z = longint'($signed(a));
      k = 1304065748;
      x = (longint'(r) * k + 16384) >>> 15;
      y = 0;
      for (int i = 0; i < CordicStages && i < 32; i++) begin
        if (z >= 0) begin
          xn = x - shr(y, i);
          y = y + shr(x, i);
          z = z - longint'(atan_lut(i[4:0]));
        end else begin
          xn = x + shr(y, i);
          y = y - shr(x, i);
          z = z + longint'(atan_lut(i[4:0]));
        end
        x = xn;
      end
      p.x = round_out(x, neg);
      p.y = round_out(y, neg);
      due_q = {due_q, p};
    endfunction

    task check_point(logic [39:0] d);
      point_t e;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected point %h", d));
        return;
      end
      e = due_q.pop_front();
      if (d[16:0] !== e.x)
        report($sformatf("x got %0d exp %0d", $signed(d[16:0]), e.x));
      if (d[33:17] !== e.y)
        report($sformatf("y got %0d exp %0d", $signed(d[33:17]), e.y));
      if (d[39:34] !== 6'd0) report("pad bits not zero");
    endtask
  endclass

  point_scoreboard sb = new();

  // Result side: random stalls, check on transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        sb.check_point(out_tdata);
        n_points++;
      end
      out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] v);
    in_tvalid <= 1'b0;
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // Idle until every point is back, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Valid stays high after a transfer; it drops only while idling
  task automatic send(logic [15:0] r, bit fin, bit st);
    while (!quiet && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= r; in_tuser <= {st, fin};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(r, fin, st);
    n_samples++;
  endtask

  // Random scans: mostly finite samples, some non-finite and odd starts
  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      logic [15:0] r;
      case ($urandom_range(3))
        0: r = 16'(16'hFFFF - $urandom_range(15));
        1: r = 16'($urandom_range(15));
        default: r = 16'($urandom());
      endcase
      send(r, $urandom_range(9) != 0, (i % 37 == 0) || ($urandom_range(49) == 0));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no scan start after reset, extremes, non-finite, folding
    send(16'd1000, 1'b1, 1'b0);
    send(16'hFFFF, 1'b1, 1'b0);
    send(16'd0, 1'b1, 1'b1);
    drain();
    write_cfg(RegStartAngle, 32'h4000_0000);
    write_cfg(RegAngleStep, 32'h2000_0000);
    for (int i = 0; i < 10; i++) send(16'hFFFF, i != 3, i == 0);
    send(16'h5555, 1'b1, 1'b0);
    send(16'hAAAA, 1'b1, 1'b1);
    drain();
    write_cfg(RegStartAngle, 32'hFFFF_FFFF);
    write_cfg(RegAngleStep, 32'h8000_0000);
    for (int i = 0; i < 4; i++) send(16'hFFFF, 1'b1, i == 0);
    drain();
    write_cfg(2'd2, 32'h1234_5678);
    write_cfg(2'd3, 32'hFFFF_FFFF);
    send(16'd777, 1'b0, 1'b1);
    send(16'd777, 1'b1, 1'b0);
    drain();

    // Random settings, one with no idling at all
    for (int ph = 0; ph < 6; ph++) begin
      logic [31:0] s;
      logic [31:0] st;
      s = (ph == 0) ? 32'h7FFF_FFFF : $urandom();
      st = (ph == 1) ? 32'd0 : $urandom();
      if (ph >= 4) s = $urandom_range(4000) - 2000;
      write_cfg(RegAngleStep, s);
      write_cfg(RegStartAngle, st);
      quiet = (ph == 2);
      random_phase(165);
      quiet = 1'b0;
      drain();
    end

    $display("Covered %0d samples, %0d points over several angle settings,",
             n_samples, n_points);
    $display("including non-finite samples, extreme ranges and all quadrants.");
    if (n_fail == 0 && sb.due_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Test completed with failures");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/pstc_pkg.sv
sv/polar_scan_to_cartesian_core.sv
tb/tb_top.sv
